>>> rtl/ita_pkg.sv
// Package: shared constants, codes and item types of the integer-to-ASCII formatter.
package ita_pkg;

    // Widest operand width (width code 2)
    localparam int VALUE_WIDTH = 32;
    // Width of the value field on the input item
    localparam int IN_WIDTH    = 32;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Decimal digits needed for VALUE_WIDTH bits: floor(VALUE_WIDTH * log10(2)) + 1
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int BCD_WIDTH  = 4 * DEC_DIGITS;
    localparam int SR_WIDTH   = max_int(max_int(BCD_WIDTH, 4 * HEX_DIGITS), VALUE_WIDTH);
    localparam int MAX_DIGITS = max_int(VALUE_WIDTH, DEC_DIGITS);
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int SHIFT_W    = $clog2(SR_WIDTH + 1);
    localparam int NBITS_W    = $clog2(VALUE_WIDTH + 1);

    // Format commands
    localparam logic [2:0] CMD_DEC       = 3'd0;
    localparam logic [2:0] CMD_BIN_TRIM  = 3'd1;
    localparam logic [2:0] CMD_BIN_FULL  = 3'd2;
    localparam logic [2:0] CMD_BIN_GROUP = 3'd3;
    localparam logic [2:0] CMD_HEX_TRIM  = 3'd4;
    localparam logic [2:0] CMD_HEX_FULL  = 3'd5;
    localparam logic [2:0] CMD_HEX_GROUP = 3'd6;
    localparam logic [2:0] CMD_NONE      = 3'd7;

    // Width codes; any other code selects the full width
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;

    // ASCII codes
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_A     = 8'h41;
    localparam logic [7:0] ASC_LOW_B = 8'h62;
    localparam logic [7:0] ASC_LOW_X = 8'h78;
    localparam logic [7:0] ASC_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]          command;
        logic [1:0]          width_code;
        logic [IN_WIDTH-1:0] value;
    } num_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } txt_item_t;

    // Emitter set-up for one number
    typedef struct packed {
        logic              hex;
        logic              trim;
        logic              group;
        logic [NDIG_W-1:0] ndig;
    } emit_cfg_t;

endpackage

>>> rtl/ita_bcd_conv.sv
// Iterative binary-to-BCD converter: one add-3 and shift step per cycle.
module ita_bcd_conv
    import ita_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [NBITS_W-1:0]     align,
    input  logic [NBITS_W-1:0]     nbits,
    output logic                   busy,
    output logic                   done,
    output logic [BCD_WIDTH-1:0]   bcd
);

    logic [VALUE_WIDTH-1:0] src_reg, src_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [NBITS_W-1:0]     cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [BCD_WIDTH-1:0]   bcd_adj;

    // Add 3 to every BCD digit of 5 or more
    function automatic logic [BCD_WIDTH-1:0] adjust(input logic [BCD_WIDTH-1:0] b);
        logic [BCD_WIDTH-1:0] r;
        r = b;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    assign bcd_adj = adjust(bcd_reg);

    // Load, then shift one source bit into the BCD register per cycle
    always_comb
    begin
        src_next  = src_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            src_next  = value << align;
            bcd_next  = '0;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], src_reg[VALUE_WIDTH-1]};
            src_next = src_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NBITS_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold data path
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> rtl/ita_emitter.sv
// Character sequencer: walks a digit shift register and drives the output item register.
module ita_emitter
    import ita_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  emit_cfg_t           cfg,
    input  logic [SR_WIDTH-1:0] digits,
    output logic                busy,
    output logic                txt_valid,
    input  logic                txt_stall,
    output txt_item_t           txt_item
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_PFX0,
        E_PFX1,
        E_PFX2,
        E_DIGIT,
        E_SPACE
    } emit_state_t;

    emit_state_t         state_reg, state_next;
    logic [SR_WIDTH-1:0] sr_reg, sr_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                hex_reg, hex_next;
    logic                group_reg, group_next;
    logic                started_reg, started_next;
    logic                valid_reg, valid_next;
    txt_item_t           item_reg, item_next;

    logic                slot_free;
    logic [3:0]          digit;
    logic [7:0]          digit_char;
    logic [SHIFT_W-1:0]  used_bits;
    logic [SHIFT_W-1:0]  shamt;
    logic                space_after;
    logic [SR_WIDTH-1:0] sr_shifted;

    // Output slot can take a new item when empty or being drained
    assign slot_free = !valid_reg || !txt_stall;

    // Current most significant digit
    assign digit      = hex_reg ? sr_reg[SR_WIDTH-1 -: 4] : {3'b000, sr_reg[SR_WIDTH-1]};
    assign digit_char = (digit < 4'd10) ? (ASC_ZERO + {4'b0000, digit})
                                        : (ASC_A + {4'b0000, digit} - 8'd10);
    assign sr_shifted = hex_reg ? (sr_reg << 4) : (sr_reg << 1);

    // Align the top digit to the register's top
    assign used_bits = cfg.hex ? SHIFT_W'({cfg.ndig, 2'b00}) : SHIFT_W'(cfg.ndig);
    assign shamt     = SHIFT_W'(SR_WIDTH) - used_bits;

    // Space after each group of 2 hex digits or 4 bits, not after the last
    assign space_after = group_reg && (pos_reg != '0) &&
                         (hex_reg ? (pos_reg[0] == 1'b0) : (pos_reg[1:0] == 2'b00));

    always_comb
    begin
        state_next   = state_reg;
        sr_next      = sr_reg;
        pos_next     = pos_reg;
        hex_next     = hex_reg;
        group_next   = group_reg;
        started_next = started_reg;
        item_next    = item_reg;
        valid_next   = valid_reg && txt_stall;

        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    sr_next      = digits << shamt;
                    pos_next     = POS_W'(cfg.ndig - 1'b1);
                    hex_next     = cfg.hex;
                    group_next   = cfg.group;
                    started_next = !cfg.trim;
                    state_next   = cfg.group ? E_PFX0 : E_DIGIT;
                end
            end
            E_PFX0:
            begin
                if (slot_free)
                begin
                    item_next  = '{character: ASC_ZERO, last: 1'b0};
                    valid_next = 1'b1;
                    state_next = E_PFX1;
                end
            end
            E_PFX1:
            begin
                if (slot_free)
                begin
                    item_next  = '{character: (hex_reg ? ASC_LOW_X : ASC_LOW_B), last: 1'b0};
                    valid_next = 1'b1;
                    state_next = E_PFX2;
                end
            end
            E_PFX2:
            begin
                if (slot_free)
                begin
                    item_next  = '{character: ASC_SPACE, last: 1'b0};
                    valid_next = 1'b1;
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                // Drop leading zeros, keep the lowest digit
                if (!started_reg && (digit == 4'd0) && (pos_reg != '0))
                begin
                    sr_next  = sr_shifted;
                    pos_next = pos_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    item_next    = '{character: digit_char, last: (pos_reg == '0)};
                    valid_next   = 1'b1;
                    started_next = 1'b1;
                    sr_next      = sr_shifted;
                    if (pos_reg == '0)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = space_after ? E_SPACE : E_DIGIT;
                    end
                end
            end
            E_SPACE:
            begin
                if (slot_free)
                begin
                    item_next  = '{character: ASC_SPACE, last: 1'b0};
                    valid_next = 1'b1;
                    state_next = E_DIGIT;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            valid_reg   <= 1'b0;
            pos_reg     <= '0;
            hex_reg     <= 1'b0;
            group_reg   <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            pos_reg     <= pos_next;
            hex_reg     <= hex_next;
            group_reg   <= group_next;
            started_reg <= started_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        sr_reg   <= sr_next;
        item_reg <= item_next;
    end

    assign busy      = (state_reg != E_IDLE);
    assign txt_valid = valid_reg;
    assign txt_item  = item_reg;

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Top level: formats an unsigned number as ASCII decimal, binary or hex characters.
//
// Input channel num_*: one item carries a command, a width code and a value.
// It is accepted when num_valid is high and num_stall low. num_stall stays
// high while a number is being converted or its characters sent.
// Output channel txt_*: one item per character, most significant first,
// with last set on the final character. Command 7 gives no characters.
// Binary and hex: characters leave at one per cycle while txt_stall is low,
// after the emitter is set up; each dropped leading zero is shifted out
// with no character. Decimal first runs the add-3/shift converter, one
// operand bit (8, 16 or 32) per cycle, then sends digits the same way,
// skipping leading zeros.
// The character output is registered: when txt_stall is high the current
// item holds and the sequencer waits; no character is lost.
// Reset clears the sequencer and the output valid; the block then accepts
// a number at once.
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      num_valid,
    output logic      num_stall,
    input  num_item_t num_item,
    output logic      txt_valid,
    input  logic      txt_stall,
    output txt_item_t txt_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } top_state_t;

    top_state_t             state_reg, state_next;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] value_ext;
    logic [VALUE_WIDTH-1:0] mask;
    logic [VALUE_WIDTH-1:0] masked;
    logic [NBITS_W-1:0]     nbits;
    logic [NBITS_W-1:0]     align;
    logic [NBITS_W:0]       nbits_rnd;
    emit_cfg_t              radix_cfg;
    emit_cfg_t              dec_cfg;
    emit_cfg_t              emit_cfg;
    logic                   is_dec;
    logic                   is_none;

    logic                   conv_start;
    logic                   conv_busy;
    logic                   conv_done;
    logic [BCD_WIDTH-1:0]   bcd;

    logic                   emit_start;
    logic                   emit_busy;
    logic [SR_WIDTH-1:0]    emit_digits;

    assign num_stall = (state_reg != S_IDLE);
    assign accept    = num_valid && !num_stall;

    // Decode operand width and mask the value
    assign value_ext = VALUE_WIDTH'(num_item.value);
    always_comb
    begin
        unique case (num_item.width_code)
            WC_8:
            begin
                nbits = NBITS_W'(8);
                mask  = VALUE_WIDTH'(8'hFF);
            end
            WC_16:
            begin
                nbits = NBITS_W'(16);
                mask  = VALUE_WIDTH'(16'hFFFF);
            end
            default:
            begin
                nbits = NBITS_W'(VALUE_WIDTH);
                mask  = '1;
            end
        endcase
    end
    assign masked    = value_ext & mask;
    assign align     = NBITS_W'(VALUE_WIDTH) - nbits;
    assign nbits_rnd = {1'b0, nbits} + (NBITS_W + 1)'(3);

    // Decode command
    assign is_dec  = (num_item.command == CMD_DEC);
    assign is_none = (num_item.command == CMD_NONE);
    assign radix_cfg.hex   = (num_item.command == CMD_HEX_TRIM) ||
                             (num_item.command == CMD_HEX_FULL) ||
                             (num_item.command == CMD_HEX_GROUP);
    assign radix_cfg.trim  = (num_item.command == CMD_BIN_TRIM) ||
                             (num_item.command == CMD_HEX_TRIM);
    assign radix_cfg.group = (num_item.command == CMD_BIN_GROUP) ||
                             (num_item.command == CMD_HEX_GROUP);
    assign radix_cfg.ndig  = radix_cfg.hex ? NDIG_W'(nbits_rnd >> 2) : NDIG_W'(nbits);

    // Decimal prints the BCD digits as trimmed hex
    assign dec_cfg = '{hex: 1'b1, trim: 1'b1, group: 1'b0, ndig: NDIG_W'(DEC_DIGITS)};

    // Start the converter or the emitter
    assign conv_start  = accept && is_dec;
    assign emit_start  = (accept && !is_dec && !is_none) || ((state_reg == S_CONV) && conv_done);
    assign emit_cfg    = (state_reg == S_CONV) ? dec_cfg : radix_cfg;
    assign emit_digits = (state_reg == S_CONV) ? SR_WIDTH'(bcd) : SR_WIDTH'(masked);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_dec)
                begin
                    state_next = S_CONV;
                end
                else if (accept && !is_none)
                begin
                    state_next = S_EMIT;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    ita_bcd_conv u_bcd_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (masked),
        .align (align),
        .nbits (nbits),
        .busy  (conv_busy),
        .done  (conv_done),
        .bcd   (bcd)
    );

    ita_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit_start),
        .cfg       (emit_cfg),
        .digits    (emit_digits),
        .busy      (emit_busy),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt_item  (txt_item)
    );

    // A number that makes characters blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_none |=> num_stall)
        else $error("input not stalled after accepting a number");

    // Converter and emitter never work at the same time
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(conv_busy && emit_busy))
        else $error("converter and emitter busy together");

    // The emitter is only started when idle
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_start |-> !emit_busy)
        else $error("emitter started while busy");

endmodule

>>> test/tb_integer_to_ascii_formatter.sv
// Testbench: directed and random numbers through the integer-to-ASCII formatter, text checked.
module tb_integer_to_ascii_formatter
    import ita_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Width codes that the package leaves unnamed: full width, and the spare code
    localparam logic [1:0] WC_32    = 2'd2;
    localparam logic [1:0] WC_SPARE = 2'd3;

    // Directed rows with this text take their characters from the predictor
    localparam string PREDICT = "?";

    localparam int RANDOM_NUMBERS = 246;
    localparam int QUIET_TAIL     = 40;
    localparam int DRAIN_POINT    = 120;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_PRINTED    = 30;

    logic      clk;
    logic      rst_n;
    logic      num_valid;
    logic      num_stall;
    num_item_t num_item;
    logic      txt_valid;
    logic      txt_stall;
    txt_item_t txt_item;

    // Characters of one number, and the text still owed by the block
    logic [7:0] line_chars[$];
    txt_item_t  expected_text[$];

    // Directed stimulus
    num_item_t directed_items[$];
    string     directed_texts[$];

    int        mismatch_count;
    int        chars_checked;
    int        numbers_by_command[8];
    logic [1:0] idle_mode;   // bit 0: sender gaps, bit 1: receiver stalls
    int        stall_left;

    integer_to_ascii_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num_item  (num_item),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt_item  (txt_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Work out the text of one number into line_chars
    function automatic void format_number(input num_item_t it);
        int          nbits;
        int          bits;
        int          ndig;
        int          group_size;
        int          pos;
        logic [31:0] mask;
        logic [31:0] masked;
        logic [31:0] rest;
        logic [31:0] digit;
        logic        hex;
        logic        trim;
        logic        group;
        logic        started;

        line_chars.delete();
        case (it.width_code)
            WC_8:    nbits = 8;
            WC_16:   nbits = 16;
            default: nbits = VALUE_WIDTH;
        endcase
        mask   = (nbits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        masked = it.value & mask;

        case (it.command)
            CMD_DEC:
            begin
                // Peel off decimal digits, least significant first
                rest = masked;
                do
                begin
                    line_chars.push_front(ASC_ZERO + 8'(rest % 32'd10));
                    rest = rest / 32'd10;
                end
                while (rest != 32'd0);
            end
            CMD_BIN_TRIM, CMD_BIN_FULL, CMD_BIN_GROUP,
            CMD_HEX_TRIM, CMD_HEX_FULL, CMD_HEX_GROUP:
            begin
                hex   = (it.command == CMD_HEX_TRIM) || (it.command == CMD_HEX_FULL)
                        || (it.command == CMD_HEX_GROUP);
                trim  = (it.command == CMD_BIN_TRIM) || (it.command == CMD_HEX_TRIM);
                group = (it.command == CMD_BIN_GROUP) || (it.command == CMD_HEX_GROUP);
                bits       = hex ? 4 : 1;
                ndig       = hex ? (nbits + 3) / 4 : nbits;
                group_size = hex ? 2 : 4;
                started    = !trim;
                if (group)
                begin
                    line_chars.push_back(ASC_ZERO);
                    line_chars.push_back(hex ? ASC_LOW_X : ASC_LOW_B);
                    line_chars.push_back(ASC_SPACE);
                end
                for (pos = ndig - 1; pos >= 0; pos--)
                begin
                    digit = (masked >> (pos * bits)) & (hex ? 32'hF : 32'h1);
                    // Drop leading zeros, but keep the last digit
                    if (started || digit != 32'd0 || pos == 0)
                    begin
                        started = 1'b1;
                        line_chars.push_back((digit < 32'd10) ? ASC_ZERO + 8'(digit)
                                                              : ASC_A + 8'(digit - 32'd10));
                        if (group && pos > 0 && (pos % group_size) == 0)
                            line_chars.push_back(ASC_SPACE);
                    end
                end
            end
            default:
            begin
                // Unused command: no text
            end
        endcase
    endfunction

    // Append line_chars to the owed text, marking the final character
    function automatic void owe_text();
        txt_item_t ch;

        foreach (line_chars[i])
        begin
            ch.character = line_chars[i];
            ch.last      = (i == line_chars.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [1:0] wc,
                           input logic [31:0] value, input string text);
        num_item_t it;

        it.command    = cmd;
        it.width_code = wc;
        it.value      = value;
        directed_items.push_back(it);
        directed_texts.push_back(text);
    endtask

    // Hold valid low for a number of cycles
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            num_valid <= 1'b0;
        end
    endtask

    // Offer one number and wait until it is taken; then record its text
    task automatic send_number(input num_item_t it, input string text);
        @(negedge clk);
        num_valid <= 1'b1;
        num_item  <= it;
        do
            @(posedge clk);
        while (num_stall);
        if (text == PREDICT)
            format_number(it);
        else
        begin
            line_chars.delete();
            for (int i = 0; i < text.len(); i++)
                line_chars.push_back(text[i]);
        end
        owe_text();
        numbers_by_command[it.command]++;
        if (idle_mode[0] && $urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 11));
    endtask

    task automatic wait_for_text();
        idle_cycles(1);
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 15));
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
            3:       return $urandom() << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: stall in random bursts while enabled
    initial
    begin
        txt_stall  = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                txt_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_mode[1] && $urandom_range(0, 3) == 0)
            begin
                txt_stall  <= 1'b1;
                stall_left = $urandom_range(0, 10);
            end
            else
                txt_stall <= 1'b0;
        end
    end

    // Check each character taken against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && txt_valid && !txt_stall)
        begin
            if (expected_text.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          txt_item.character, txt_item.last));
            else
            begin
                if (txt_item.character !== expected_text[0].character)
                    report_mismatch($sformatf("character %0d: got 0x%02h, expected 0x%02h",
                                              chars_checked, txt_item.character,
                                              expected_text[0].character));
                if (txt_item.last !== expected_text[0].last)
                    report_mismatch($sformatf("character %0d: last got %0b, expected %0b",
                                              chars_checked, txt_item.last,
                                              expected_text[0].last));
                void'(expected_text.pop_front());
            end
            chars_checked++;
        end
    end

    // Stimulus
    initial
    begin
        num_item_t it;
        int        formatted;
        int        chunk;
        logic      drained;

        rst_n          = 1'b0;
        num_valid      = 1'b0;
        num_item       = '0;
        idle_mode      = 2'b00;
        mismatch_count = 0;
        chars_checked  = 0;
        foreach (numbers_by_command[i])
            numbers_by_command[i] = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Extremes, every command, masking, spare width code, unused command
        add_row(CMD_DEC,       WC_8,     32'h0000_0000, "0");
        add_row(CMD_DEC,       WC_8,     32'h0000_00FF, "255");
        add_row(CMD_DEC,       WC_16,    32'h0000_FFFF, "65535");
        add_row(CMD_DEC,       WC_32,    32'hFFFF_FFFF, "4294967295");
        add_row(CMD_DEC,       WC_32,    32'd1000000000, "1000000000");
        add_row(CMD_DEC,       WC_SPARE, 32'h0BC6_14E0, PREDICT);
        add_row(CMD_DEC,       WC_8,     32'h1234_5600, "0");
        add_row(CMD_BIN_TRIM,  WC_8,     32'h0000_0000, "0");
        add_row(CMD_BIN_TRIM,  WC_16,    32'h0000_0001, "1");
        add_row(CMD_BIN_TRIM,  WC_32,    32'h8000_0000, PREDICT);
        add_row(CMD_BIN_FULL,  WC_8,     32'h0000_00FF, "11111111");
        add_row(CMD_BIN_FULL,  WC_32,    32'h0000_0000, PREDICT);
        add_row(CMD_BIN_GROUP, WC_8,     32'h0000_00A5, "0b 1010 0101");
        add_row(CMD_BIN_GROUP, WC_32,    32'hFFFF_FFFF, PREDICT);
        add_row(CMD_HEX_TRIM,  WC_16,    32'h0000_0000, "0");
        add_row(CMD_HEX_TRIM,  WC_32,    32'h000A_BC00, PREDICT);
        add_row(CMD_HEX_TRIM,  WC_32,    32'hFFFF_FFFF, "FFFFFFFF");
        add_row(CMD_HEX_FULL,  WC_8,     32'h1234_5678, "78");
        add_row(CMD_HEX_FULL,  WC_16,    32'h0000_0000, "0000");
        add_row(CMD_HEX_GROUP, WC_16,    32'h0000_0000, "0x 00 00");
        add_row(CMD_HEX_GROUP, WC_32,    32'hFFFF_FFFF, "0x FF FF FF FF");
        add_row(CMD_HEX_GROUP, WC_SPARE, 32'h0F1E_2D3C, PREDICT);
        add_row(CMD_NONE,      WC_32,    32'hFFFF_FFFF, "");
        add_row(CMD_NONE,      WC_8,     32'h0000_0000, "");

        idle_mode = 2'($urandom_range(0, 3));
        foreach (directed_items[i])
            send_number(directed_items[i], directed_texts[i]);
        wait_for_text();

        // Random numbers in chunks of differing idle patterns, quiet at the end
        formatted = 0;
        chunk     = -1;
        drained   = 1'b0;
        while (formatted < RANDOM_NUMBERS)
        begin
            if (formatted >= RANDOM_NUMBERS - QUIET_TAIL)
                idle_mode = 2'b00;
            else if (formatted / 30 != chunk)
            begin
                chunk     = formatted / 30;
                idle_mode = 2'($urandom_range(0, 3));
            end
            if (formatted == DRAIN_POINT && !drained)
            begin
                wait_for_text();
                drained = 1'b1;
            end
            it.command    = 3'($urandom_range(0, 7));
            it.width_code = 2'($urandom_range(0, 3));
            it.value      = pick_value();
            send_number(it, PREDICT);
            formatted++;
        end
        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d numbers: %0d decimal, %0d binary, %0d hex, %0d unused command",
                 numbers_by_command.sum(), numbers_by_command[CMD_DEC],
                 numbers_by_command[CMD_BIN_TRIM] + numbers_by_command[CMD_BIN_FULL]
                 + numbers_by_command[CMD_BIN_GROUP],
                 numbers_by_command[CMD_HEX_TRIM] + numbers_by_command[CMD_HEX_FULL]
                 + numbers_by_command[CMD_HEX_GROUP],
                 numbers_by_command[CMD_NONE]);
        $display("Checked %0d characters across all widths, %0d mismatches",
                 chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Give up if the block hangs
    initial
    begin
        #20ms;
        $display("Timed out with %0d characters still owed", expected_text.size());
        $display("FAILURE");
        $finish;
    end

endmodule

>>> integer_to_ascii_formatter.f
rtl/ita_pkg.sv
rtl/ita_bcd_conv.sv
rtl/ita_emitter.sv
rtl/integer_to_ascii_formatter.sv
test/tb_integer_to_ascii_formatter.sv
